>>> rtl/core/tcfa_pkg.sv
// Package for the two-class FIFO pair with aging.
// Holds request, status and controller state codes; no dependencies.

package tcfa_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_AGE  = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_AGE_CHK,
        S_DONE
    } state_e_t;

    localparam int        ID_W                = 8;
    localparam int        TIME_W              = 32;
    localparam int        THR_W               = 16;
    localparam int        PROM_W              = 5;
    localparam logic [THR_W-1:0] RESET_AGE_THRESHOLD = 16'd400;

endpackage

>>> rtl/core/tcfa_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Generic storage used for both queues; no package dependencies.

module tcfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/two_class_fifo_with_aging.sv
// Top level: controller, queue pointers and result register for the FIFO pair.
// Depends on tcfa_pkg and tcfa_ram.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------------------
//  in       | in_valid / in_stall          | req_type, car_id, is_vip, now_ms
//  out      | out_valid / out_stall        | status, out_car_id, out_from_vip,
//           |                              | promoted_count
//  cfg      | cfg_we (no handshake)        | cfg_wdata (age threshold)
//
// Push, unused codes and a pop on two empty queues go through S_EXEC and S_DONE; a pop
// that returns an entry also passes S_POP_WAIT. Aging enters S_AGE_CHK for each regular
// head examined: each head is read from the regular queue RAM and compared; an old
// enough head is written to the priority queue RAM, a younger one ends the pass.
// One transaction is worked on at a time; in_stall is low only in the idle state.
// A finished result waits in the output register, so a new transaction is taken
// while out_stall holds the previous one.
// Reset (rst_n, async, active low) empties both queues; RAM contents are not cleared.

module two_class_fifo_with_aging #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  car_id,
    input  logic        is_vip,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  out_car_id,
    output logic        out_from_vip,
    output logic [4:0]  promoted_count
);

    import tcfa_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = ID_W + TIME_W;
    localparam logic [AW-1:0] LAST_IDX  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ALMOST_FULL = CW'(QUEUE_DEPTH - 1);

    state_e_t             state_reg, state_next;
    logic [1:0]           req_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 vip_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [THR_W-1:0]     thr_reg;

    logic [AW-1:0]        reg_head_reg, reg_head_next;
    logic [AW-1:0]        reg_tail_reg, reg_tail_next;
    logic [CW-1:0]        reg_count_reg, reg_count_next;
    logic [AW-1:0]        pri_head_reg, pri_head_next;
    logic [AW-1:0]        pri_tail_reg, pri_tail_next;
    logic [CW-1:0]        pri_count_reg, pri_count_next;

    status_e_t            res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic                 res_vip_reg, res_vip_next;
    logic [PROM_W-1:0]    res_prom_reg, res_prom_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_vip_reg, out_vip_next;
    logic [PROM_W-1:0]    out_prom_reg, out_prom_next;

    logic                 reg_we, reg_re;
    logic [AW-1:0]        reg_waddr, reg_raddr;
    logic [RW-1:0]        reg_wdata, reg_rdata;
    logic                 pri_we, pri_re;
    logic [AW-1:0]        pri_waddr, pri_raddr;
    logic [ID_W-1:0]      pri_wdata, pri_rdata;

    logic [AW-1:0]        reg_head_inc, reg_tail_inc, pri_head_inc, pri_tail_inc;
    logic [TIME_W-1:0]    head_age;
    logic                 in_accept;
    logic                 out_free;

    assign reg_head_inc = (reg_head_reg == LAST_IDX) ? '0 : reg_head_reg + AW'(1);
    assign reg_tail_inc = (reg_tail_reg == LAST_IDX) ? '0 : reg_tail_reg + AW'(1);
    assign pri_head_inc = (pri_head_reg == LAST_IDX) ? '0 : pri_head_reg + AW'(1);
    assign pri_tail_inc = (pri_tail_reg == LAST_IDX) ? '0 : pri_tail_reg + AW'(1);

    // wrap-around age of the regular head being examined
    assign head_age  = now_reg - reg_rdata[TIME_W-1:0];
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    tcfa_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (reg_re),
        .raddr (reg_raddr),
        .rdata (reg_rdata)
    );

    tcfa_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_pri_ram (
        .clk   (clk),
        .we    (pri_we),
        .waddr (pri_waddr),
        .wdata (pri_wdata),
        .re    (pri_re),
        .raddr (pri_raddr),
        .rdata (pri_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        reg_head_next   = reg_head_reg;
        reg_tail_next   = reg_tail_reg;
        reg_count_next  = reg_count_reg;
        pri_head_next   = pri_head_reg;
        pri_tail_next   = pri_tail_reg;
        pri_count_next  = pri_count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_vip_next    = res_vip_reg;
        res_prom_next   = res_prom_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_vip_next    = out_vip_reg;
        out_prom_next   = out_prom_reg;
        reg_we          = 1'b0;
        reg_waddr       = reg_tail_reg;
        reg_wdata       = {id_reg, now_reg};
        reg_re          = 1'b0;
        reg_raddr       = reg_head_reg;
        pri_we          = 1'b0;
        pri_waddr       = pri_tail_reg;
        pri_wdata       = id_reg;
        pri_re          = 1'b0;
        pri_raddr       = pri_head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    res_vip_next    = 1'b0;
                    res_prom_next   = '0;
                    state_next      = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (req_reg)
                    REQ_PUSH:
                    begin
                        if (vip_reg)
                        begin
                            if (pri_count_reg == FULL_CNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                pri_we         = 1'b1;
                                pri_tail_next  = pri_tail_inc;
                                pri_count_next = pri_count_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            if (reg_count_reg == FULL_CNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                reg_we         = 1'b1;
                                reg_tail_next  = reg_tail_inc;
                                reg_count_next = reg_count_reg + CW'(1);
                            end
                        end
                    end

                    REQ_POP:
                    begin
                        priority if (pri_count_reg != '0)
                        begin
                            pri_re         = 1'b1;
                            pri_head_next  = pri_head_inc;
                            pri_count_next = pri_count_reg - CW'(1);
                            res_vip_next   = 1'b1;
                            state_next     = S_POP_WAIT;
                        end
                        else if (reg_count_reg != '0)
                        begin
                            reg_re         = 1'b1;
                            reg_head_next  = reg_head_inc;
                            reg_count_next = reg_count_reg - CW'(1);
                            state_next     = S_POP_WAIT;
                        end
                        else
                        begin
                            res_status_next = ST_EMPTY;
                        end
                    end

                    REQ_AGE:
                    begin
                        if (reg_count_reg != '0 && pri_count_reg != FULL_CNT)
                        begin
                            reg_re     = 1'b1;
                            state_next = S_AGE_CHK;
                        end
                    end

                    default:
                    begin
                        // unused request code: plain ok result, no state change
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                res_id_next = res_vip_reg ? pri_rdata : reg_rdata[RW-1:TIME_W];
                state_next  = S_DONE;
            end

            S_AGE_CHK:
            begin
                state_next = S_DONE;
                if (head_age >= {{(TIME_W-THR_W){1'b0}}, thr_reg})
                begin
                    pri_we         = 1'b1;
                    pri_wdata      = reg_rdata[RW-1:TIME_W];
                    pri_tail_next  = pri_tail_inc;
                    pri_count_next = pri_count_reg + CW'(1);
                    reg_head_next  = reg_head_inc;
                    reg_count_next = reg_count_reg - CW'(1);
                    res_prom_next  = res_prom_reg + PROM_W'(1);
                    // read the next head right away while both queues allow another move
                    if (reg_count_reg != CW'(1) && pri_count_reg != ALMOST_FULL)
                    begin
                        reg_re     = 1'b1;
                        reg_raddr  = reg_head_inc;
                        state_next = S_AGE_CHK;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_vip_next    = res_vip_reg;
                    out_prom_next   = res_prom_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= RESET_AGE_THRESHOLD;
            reg_head_reg  <= '0;
            reg_tail_reg  <= '0;
            reg_count_reg <= '0;
            pri_head_reg  <= '0;
            pri_tail_reg  <= '0;
            pri_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            reg_head_reg  <= reg_head_next;
            reg_tail_reg  <= reg_tail_next;
            reg_count_reg <= reg_count_next;
            pri_head_reg  <= pri_head_next;
            pri_tail_reg  <= pri_tail_next;
            pri_count_reg <= pri_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= req_type;
            id_reg  <= car_id;
            vip_reg <= is_vip;
            now_reg <= now_ms;
        end
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_vip_reg    <= res_vip_next;
        res_prom_reg   <= res_prom_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_vip_reg    <= out_vip_next;
        out_prom_reg   <= out_prom_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign out_car_id     = out_id_reg;
    assign out_from_vip   = out_vip_reg;
    assign promoted_count = out_prom_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reg_count_reg <= FULL_CNT && pri_count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_pri_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        pri_we |-> pri_count_reg != FULL_CNT)
        else $error("priority write into full queue");

    a_age_head_present: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AGE_CHK |-> reg_count_reg != '0)
        else $error("aging check with empty regular queue");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    a_single_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(reg_re && pri_re) && !(reg_we && reg_re))
        else $error("conflicting queue RAM accesses");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for two_class_fifo_with_aging.
// Drives push, pop and aging transactions with random idling and checks every result
// against a behavioral model kept here; depends on tcfa_pkg and the RTL.

module tb;
    import tcfa_pkg::*;

    localparam int DEPTH        = 16;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;  // not in req_e_t, must be ignored

    // req kept as raw bits so the unused code can be sent
    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  id;
        logic        vip;
        logic [31:0] now;
    } car_req_t;

    typedef struct packed {
        status_e_t   status;
        logic [7:0]  id;
        logic        from_vip;
        logic [4:0]  promoted;
    } car_result_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] stamp;
    } waiting_car_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [7:0]  car_id = '0;
    logic        is_vip = 1'b0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [7:0]  out_car_id;
    logic        out_from_vip;
    logic [4:0]  promoted_count;

    car_req_t     pending_reqs[$];
    car_result_t  expected_results[$];
    waiting_car_t regular_line[$];
    logic [7:0]   vip_line[$];
    logic [15:0]  age_limit = RESET_AGE_THRESHOLD;
    logic [31:0]  clock_ms = '0;
    logic         in_taken = 1'b0;
    logic         calm = 1'b0;
    int           items_queued = 0;
    int           results_seen = 0;
    int           fail_count = 0;
    int           hold_left = 0;
    int           next_hold_at = 100;
    int           quiet_cycles = 0;

    two_class_fifo_with_aging #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .car_id         (car_id),
        .is_vip         (is_vip),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_car_id     (out_car_id),
        .out_from_vip   (out_from_vip),
        .promoted_count (promoted_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one transaction to the model queues and returns the result it must produce.
    function automatic car_result_t serve_request(input car_req_t r);
        car_result_t  o;
        waiting_car_t head;
        logic [31:0]  age;
        logic         aging;
        o = '{status: ST_OK, id: 8'd0, from_vip: 1'b0, promoted: 5'd0};
        case (r.req)
            REQ_PUSH:
            begin
                if (r.vip) begin
                    if (vip_line.size() >= DEPTH)
                        o.status = ST_FULL;
                    else
                        vip_line.push_back(r.id);
                end
                else begin
                    if (regular_line.size() >= DEPTH)
                        o.status = ST_FULL;
                    else
                        regular_line.push_back('{id: r.id, stamp: r.now});
                end
            end
            REQ_POP:
            begin
                if (vip_line.size() > 0) begin
                    o.id = vip_line.pop_front();
                    o.from_vip = 1'b1;
                end
                else if (regular_line.size() > 0) begin
                    head = regular_line.pop_front();
                    o.id = head.id;
                end
                else
                    o.status = ST_EMPTY;
            end
            REQ_AGE:
            begin
                aging = 1'b1;
                while (aging && regular_line.size() > 0 && vip_line.size() < DEPTH) begin
                    head = regular_line[0];
                    age = r.now - head.stamp;  // wraps modulo 2^32
                    if (age < {16'd0, age_limit})
                        aging = 1'b0;
                    else begin
                        vip_line.push_back(head.id);
                        void'(regular_line.pop_front());
                        o.promoted = o.promoted + 5'd1;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic queue_item(input logic [1:0] req, input logic [7:0] id, input logic vip,
                              input logic [31:0] now);
        pending_reqs.push_back('{req: req, id: id, vip: vip, now: now});
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_age_limit(input logic [15:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        age_limit = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic built from short sequences: mixed singles, fill bursts,
    // push-then-age runs, drains, and aging against a full priority queue.
    task automatic queue_traffic(input int n_items);
        int          start_n;
        int          len;
        int          k;
        int          pick;
        int          roll;
        logic [1:0]  op;
        logic        vip;
        logic [31:0] step_max;
        logic [31:0] t0;
        start_n = items_queued;
        step_max = {16'd0, age_limit} / 8 + 1;
        while (items_queued - start_n < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                len = $urandom_range(4, 12);
                for (k = 0; k < len; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        op = REQ_PUSH;
                    else if (roll < 75)
                        op = REQ_POP;
                    else if (roll < 94)
                        op = REQ_AGE;
                    else
                        op = REQ_UNUSED;
                    clock_ms += $urandom_range(0, step_max);
                    queue_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               ($urandom_range(0, 99) < 4) ? $urandom() : clock_ms);
                end
            end
            else if (pick < 6) begin
                vip = 1'($urandom_range(0, 1));
                len = $urandom_range(14, 20);
                for (k = 0; k < len; k++) begin
                    clock_ms += $urandom_range(0, 3);
                    queue_item(REQ_PUSH, 8'($urandom_range(0, 255)), vip, clock_ms);
                end
            end
            else if (pick < 8) begin
                len = $urandom_range(1, 8);
                t0 = clock_ms;
                for (k = 0; k < len; k++) begin
                    queue_item(REQ_PUSH, 8'($urandom_range(0, 255)), 1'b0, clock_ms);
                    clock_ms += $urandom_range(0, step_max);
                end
                // land exactly on, just under, or past the threshold of the first push
                roll = $urandom_range(0, 3);
                if (roll == 0)
                    clock_ms = t0 + age_limit - 1;
                else if (roll == 1)
                    clock_ms = t0 + age_limit;
                else
                    clock_ms = t0 + age_limit + $urandom_range(0, step_max * 4);
                queue_item(REQ_AGE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           clock_ms);
                if ($urandom_range(0, 1)) begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++)
                        queue_item(REQ_POP, 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), clock_ms);
                end
            end
            else if (pick == 8) begin
                len = $urandom_range(6, 34);
                for (k = 0; k < len; k++) begin
                    clock_ms += $urandom_range(0, step_max);
                    queue_item(REQ_POP, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), clock_ms);
                end
            end
            else begin
                for (k = 0; k < DEPTH + 1; k++)
                    queue_item(REQ_PUSH, 8'($urandom_range(0, 255)), 1'b1, clock_ms);
                t0 = clock_ms;
                for (k = 0; k < 3; k++)
                    queue_item(REQ_PUSH, 8'($urandom_range(0, 255)), 1'b0, clock_ms);
                clock_ms = t0 + age_limit + 5;
                // priority queue is full: nothing may move, then room for two
                queue_item(REQ_AGE, 8'd0, 1'b0, clock_ms);
                queue_item(REQ_POP, 8'd0, 1'b0, clock_ms);
                queue_item(REQ_POP, 8'd0, 1'b0, clock_ms);
                queue_item(REQ_AGE, 8'd0, 1'b0, clock_ms);
            end
        end
    endtask

    // Sender pacing; payload holds while a transaction is stalled.
    always @(negedge clk)
    begin : driver
        car_req_t nxt;
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.req;
                    car_id <= nxt.id;
                    is_vip <= nxt.vip;
                    now_ms <= nxt.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver pacing, with its own count of hold-off cycles.
    always @(negedge clk)
    begin : receiver
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (results_seen >= next_hold_at) begin
                // long receiver hold-off so the block backs up into in_stall
                hold_left = HOLD_CYCLES;
                next_hold_at = next_hold_at + 300;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : monitor
        car_result_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (out_car_id !== want.id) begin
                        $error("out_car_id: expected %0d, actual %0d", want.id, out_car_id);
                        fail_count++;
                    end
                    if (out_from_vip !== want.from_vip) begin
                        $error("out_from_vip: expected %0d, actual %0d", want.from_vip,
                               out_from_vip);
                        fail_count++;
                    end
                    if (promoted_count !== want.promoted) begin
                        $error("promoted_count: expected %0d, actual %0d", want.promoted,
                               promoted_count);
                        fail_count++;
                    end
                    results_seen++;
                end
            end
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_results.push_back(serve_request('{req: req_type, id: car_id,
                                                           vip: is_vip, now: now_ms}));
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, ignored code, aging boundary, class order, time wrap
        queue_item(REQ_POP, 8'd0, 1'b0, 32'd0);
        queue_item(REQ_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        queue_item(REQ_AGE, 8'd0, 1'b0, 32'd0);
        queue_item(REQ_PUSH, 8'h00, 1'b0, 32'd0);
        queue_item(REQ_PUSH, 8'hFF, 1'b0, 32'd10);
        queue_item(REQ_PUSH, 8'hA5, 1'b1, 32'd20);
        queue_item(REQ_AGE, 8'd0, 1'b0, 32'd399);
        queue_item(REQ_AGE, 8'd0, 1'b0, 32'd400);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'd401);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'd402);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'd403);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'd404);
        queue_item(REQ_PUSH, 8'h5A, 1'b0, 32'hFFFF_FF00);
        queue_item(REQ_AGE, 8'd0, 1'b0, 32'h0000_008F);
        queue_item(REQ_AGE, 8'd0, 1'b0, 32'h0000_0090);
        queue_item(REQ_PUSH, 8'h01, 1'b1, 32'h0000_0091);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'h0000_0092);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'h0000_0093);
        queue_item(REQ_POP, 8'd0, 1'b0, 32'h0000_0094);
        clock_ms = 32'd1000;
        queue_traffic(110);

        set_age_limit(16'd0);
        queue_traffic(130);

        set_age_limit(16'hFFFF);
        clock_ms = 32'hFFFF_8000;
        queue_traffic(150);

        set_age_limit(16'($urandom_range(1, 2000)));
        calm = 1'b1;
        queue_traffic(150);

        set_age_limit(16'($urandom_range(0, 65535)));
        calm = 1'b0;
        queue_traffic(150);

        wait_drained();
        repeat (25) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
